// ===== sv/ctss_pkg.sv =====
// shared types, widths and constants of the class trace statistics block
package ctss_pkg;

   localparam int POINTS  = 1024;
   localparam int CLASSES = 256;

   localparam int PT_W   = $clog2(POINTS);
   localparam int CL_W   = $clog2(CLASSES);
   localparam int ADDR_W = CL_W + PT_W;
   localparam int SMP_W  = 16;
   localparam int SUM_W  = 40;
   localparam int CSUM_W = 56;
   localparam int CNT_W  = 25;
   localparam int MEAN_W = 24;
   localparam int V_W    = 40;
   localparam int MSUM_W = MEAN_W + CL_W;
   localparam int VSUM_W = V_W + CL_W;
   localparam int NCL_W  = CL_W + 1;
   localparam int PROD_W = 2 * (MEAN_W + 1);

   localparam int DVD_W     = 56;
   localparam int DVS_W     = CNT_W;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 120;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [V_W-1:0]   V_MAX   = '1;
   localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
   localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_CENTER = 2'd1,
      OP_FINAL  = 2'd2
   } opcode_type;

   localparam logic [1:0] OP_UNUSED_CODE = 2'd3;

   typedef struct packed {
      opcode_type              op;
      logic [CL_W-1:0]         class_value;
      logic [PT_W-1:0]         point_index;
      logic signed [SMP_W-1:0] sample;
      logic                    last_of_trace;
   } cmd_type;

endpackage

// ===== sv/ctss_ram.sv =====
// generic single write port ram with registered read
module ctss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== sv/ctss_div.sv =====
// bit-serial unsigned divider, one quotient bit per cycle
module ctss_div
   import ctss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0]     dvd_ff;
   logic [DVS_W-1:0]     dvs_ff;
   logic [DVS_W-1:0]     rem_ff;
   logic [DVD_W-1:0]     quo_ff;
   logic [DVS_W:0]       rem_shift;
   logic                 fits;

   assign rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!run_ff && start) begin
            run_ff <= 1'b1;
            cnt_ff <= DIV_CNT_W'(DVD_W - 1);
            dvd_ff <= dividend;
            dvs_ff <= divisor;
            rem_ff <= '0;
         end else if (run_ff) begin
            dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
            quo_ff <= {quo_ff[DVD_W-2:0], fits};
            rem_ff <= fits ? DVS_W'(rem_shift - {1'b0, dvs_ff}) : rem_shift[DVS_W-1:0];
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/ctss_front.sv =====
// request intake: unpacks, drops unused opcodes and queues commands
module ctss_front
   import ctss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   req_tlast,
   input  logic                   init_done,
   output cmd_type                cmd,
   output logic                   cmd_valid,
   input  logic                   cmd_pop
);

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff;
   logic [QPTR_W-1:0] rp_ff;
   logic [QPTR_W:0]   cnt_ff;
   logic              push;
   logic              pop;
   cmd_type           cmd_in;

   assign req_tready = init_done && (cnt_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && (req_tuser != OP_UNUSED_CODE);
   assign pop        = cmd_pop && cmd_valid;

   always_comb begin
      cmd_in.op            = opcode_type'(req_tuser);
      cmd_in.class_value   = req_tdata[CL_W-1:0];
      cmd_in.point_index   = req_tdata[CL_W+PT_W-1:CL_W];
      cmd_in.sample        = req_tdata[CL_W+PT_W+SMP_W-1:CL_W+PT_W];
      cmd_in.last_of_trace = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            queue_ff[wp_ff] <= cmd_in;
            wp_ff           <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign cmd_valid = cnt_ff != '0;
   assign cmd       = queue_ff[rp_ff];

endmodule

// ===== sv/ctss_back.sv =====
// command execution: class stores, accumulation, finalize walk and result register
module ctss_back
   import ctss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   output logic                   init_done,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_RD, S_O0, S_O1, S_O1_DIV, S_O1_MUL, S_O1_WR,
      S_FA, S_FA_MDIV, S_FA_VDIV, S_FA_NEXT, S_FB_MOM, S_FB, S_FB_MDIV,
      S_FB_MUL, S_FB_ACC, S_FB_NEXT, S_F_VOM, S_F_MOV, S_EMIT
   } state_type;

   state_type                state_ff;
   logic [ADDR_W-1:0]        clr_ff;
   opcode_type               op_ff;
   logic [PT_W-1:0]          pt_ff;
   logic signed [SMP_W-1:0]  smp_ff;
   logic                     last_ff;
   logic                     pass_ff;
   logic [CL_W-1:0]          k_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic [CL_W-1:0]          caddr_ff;
   logic [ADDR_W-1:0]        wa_ff;
   logic [CL_W-1:0]          cwa_ff;
   logic                     sum_we_ff;
   logic                     csum_we_ff;
   logic                     cnt_we_ff;
   logic                     ccnt_we_ff;
   logic [SUM_W-1:0]         sum_wd_ff;
   logic [CSUM_W-1:0]        csum_wd_ff;
   logic [CNT_W-1:0]         cnt_wd_ff;
   logic [CNT_W-1:0]         ccnt_wd_ff;
   logic                     div_start_ff;
   logic [DVD_W-1:0]         div_dvd_ff;
   logic [DVS_W-1:0]         div_dvs_ff;
   logic                     neg_ff;
   logic signed [MEAN_W-1:0] m_ff;
   logic signed [MEAN_W-1:0] mom_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic signed [MSUM_W-1:0] msum_ff;
   logic [NCL_W-1:0]         n_ff;
   logic [NCL_W-1:0]         nv_ff;
   logic [VSUM_W-1:0]        vsum_ff;
   logic [DVD_W-1:0]         sqsum_ff;
   logic [V_W-1:0]           vom_ff;
   logic [V_W-1:0]           mov_ff;
   logic                     nomem_ff;
   logic                     out_valid_ff;
   logic [PT_W-1:0]          out_pt_ff;
   logic [MEAN_W-1:0]        out_mom_ff;
   logic [V_W-1:0]           out_vom_ff;
   logic [V_W-1:0]           out_mov_ff;
   logic                     out_nomem_ff;

   logic signed [SUM_W-1:0]  sum_rd;
   logic [CSUM_W-1:0]        csum_rd;
   logic [CNT_W-1:0]         cnt_rd;
   logic [CNT_W-1:0]         ccnt_rd;
   logic                     div_done;
   logic [DVD_W-1:0]         div_q;

   logic signed [SUM_W:0]    sum_ext;
   logic [SUM_W-1:0]         sum_sat;
   logic [SUM_W-1:0]         sum_abs;
   logic [MSUM_W-1:0]        msum_abs;
   logic signed [MEAN_W-1:0] mean_q;
   logic signed [MEAN_W:0]   d_center;
   logic signed [MEAN_W:0]   d_spread;
   logic signed [MEAN_W:0]   mul_a;
   logic signed [PROD_W-1:0] prod;
   logic [CSUM_W:0]          csum_ext;
   logic [CSUM_W-1:0]        csum_sat;
   logic [V_W-1:0]           v_clamp;
   logic [V_W-1:0]           vom_sat;
   logic [DVD_W-1:0]         mean_dvd;

   ctss_ram #(.WIDTH(SUM_W), .DEPTH(CLASSES * POINTS)) u_sum_ram (
      .clock(clock), .wr_en(sum_we_ff), .wr_addr(wa_ff), .wr_data(sum_wd_ff),
      .rd_addr(addr_ff), .rd_data(sum_rd)
   );

   ctss_ram #(.WIDTH(CSUM_W), .DEPTH(CLASSES * POINTS)) u_csum_ram (
      .clock(clock), .wr_en(csum_we_ff), .wr_addr(wa_ff), .wr_data(csum_wd_ff),
      .rd_addr(addr_ff), .rd_data(csum_rd)
   );

   ctss_ram #(.WIDTH(CNT_W), .DEPTH(CLASSES)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we_ff), .wr_addr(cwa_ff), .wr_data(cnt_wd_ff),
      .rd_addr(caddr_ff), .rd_data(cnt_rd)
   );

   ctss_ram #(.WIDTH(CNT_W), .DEPTH(CLASSES)) u_ccnt_ram (
      .clock(clock), .wr_en(ccnt_we_ff), .wr_addr(cwa_ff), .wr_data(ccnt_wd_ff),
      .rd_addr(caddr_ff), .rd_data(ccnt_rd)
   );

   ctss_div u_div (
      .clock(clock), .reset(reset), .start(div_start_ff), .dividend(div_dvd_ff),
      .divisor(div_dvs_ff), .done(div_done), .quotient(div_q)
   );

   // class mean magnitude from the divider, signed and clamped to 24 bits
   always_comb begin
      if (neg_ff) begin
         mean_q = (div_q > DVD_W'(2 ** (MEAN_W - 1))) ? MEAN_MIN : -$signed(div_q[MEAN_W-1:0]);
      end else begin
         mean_q = (div_q > DVD_W'(MEAN_MAX)) ? MEAN_MAX : $signed(div_q[MEAN_W-1:0]);
      end
   end

   always_comb begin
      sum_ext = {sum_rd[SUM_W-1], sum_rd} + {{(SUM_W+1-SMP_W){smp_ff[SMP_W-1]}}, smp_ff};
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
         sum_sat = {sum_ext[SUM_W], {(SUM_W-1){~sum_ext[SUM_W]}}};
      end else begin
         sum_sat = sum_ext[SUM_W-1:0];
      end
      sum_abs  = sum_rd[SUM_W-1] ? SUM_W'(-sum_rd) : sum_rd;
      mean_dvd = DVD_W'({sum_abs, 8'b0});
      msum_abs = msum_ff[MSUM_W-1] ? MSUM_W'(-msum_ff) : msum_ff;

      d_center = {{(MEAN_W+1-SMP_W-8){smp_ff[SMP_W-1]}}, smp_ff, 8'b0}
                 - {m_ff[MEAN_W-1], m_ff};
      d_spread = {m_ff[MEAN_W-1], m_ff} - {mom_ff[MEAN_W-1], mom_ff};
      mul_a    = (op_ff == OP_CENTER) ? d_center : d_spread;
      prod     = mul_a * mul_a;

      csum_ext = {1'b0, csum_rd} + (CSUM_W+1)'(prod_ff[PROD_W-1:8]);
      csum_sat = csum_ext[CSUM_W] ? '1 : csum_ext[CSUM_W-1:0];

      v_clamp  = (|div_q[DVD_W-1:V_W]) ? V_MAX : div_q[V_W-1:0];
      vom_sat  = (|div_q[DVD_W-1:V_W+8]) ? V_MAX : div_q[V_W+7:8];
   end

   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
   assign init_done = state_ff != S_CLEAR;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sum_we_ff    <= 1'b0;
         csum_we_ff   <= 1'b0;
         cnt_we_ff    <= 1'b0;
         ccnt_we_ff   <= 1'b0;
         div_start_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_we_ff    <= 1'b0;
         csum_we_ff   <= 1'b0;
         cnt_we_ff    <= 1'b0;
         ccnt_we_ff   <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               // zero every store, one entry a cycle
               sum_we_ff  <= 1'b1;
               csum_we_ff <= 1'b1;
               cnt_we_ff  <= 1'b1;
               ccnt_we_ff <= 1'b1;
               wa_ff      <= clr_ff;
               cwa_ff     <= clr_ff[CL_W-1:0];
               sum_wd_ff  <= '0;
               csum_wd_ff <= '0;
               cnt_wd_ff  <= '0;
               ccnt_wd_ff <= '0;
               clr_ff     <= clr_ff + 1'b1;
               if (clr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (cmd_valid) begin
                  op_ff    <= cmd.op;
                  pt_ff    <= cmd.point_index;
                  smp_ff   <= cmd.sample;
                  last_ff  <= cmd.last_of_trace;
                  pass_ff  <= 1'b0;
                  k_ff     <= '0;
                  msum_ff  <= '0;
                  n_ff     <= '0;
                  nv_ff    <= '0;
                  vsum_ff  <= '0;
                  sqsum_ff <= '0;
                  nomem_ff <= 1'b0;
                  if (cmd.op == OP_FINAL) begin
                     addr_ff  <= {CL_W'(0), cmd.point_index};
                     caddr_ff <= '0;
                  end else begin
                     addr_ff  <= {cmd.class_value, cmd.point_index};
                     caddr_ff <= cmd.class_value;
                  end
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               case (op_ff)
                  OP_ADD:    state_ff <= S_O0;
                  OP_CENTER: state_ff <= S_O1;
                  default:   state_ff <= pass_ff ? S_FB : S_FA;
               endcase
            end
            S_O0: begin
               sum_we_ff <= 1'b1;
               wa_ff     <= addr_ff;
               sum_wd_ff <= sum_sat;
               if (last_ff && cnt_rd != CNT_MAX) begin
                  cnt_we_ff <= 1'b1;
                  cwa_ff    <= caddr_ff;
                  cnt_wd_ff <= cnt_rd + 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_O1: begin
               if (cnt_rd == '0) begin
                  m_ff     <= '0;
                  state_ff <= S_O1_MUL;
               end else begin
                  div_start_ff <= 1'b1;
                  div_dvd_ff   <= mean_dvd;
                  div_dvs_ff   <= cnt_rd;
                  neg_ff       <= sum_rd[SUM_W-1];
                  state_ff     <= S_O1_DIV;
               end
            end
            S_O1_DIV: begin
               if (div_done) begin
                  m_ff     <= mean_q;
                  state_ff <= S_O1_MUL;
               end
            end
            S_O1_MUL: begin
               prod_ff  <= prod;
               state_ff <= S_O1_WR;
            end
            S_O1_WR: begin
               csum_we_ff <= 1'b1;
               wa_ff      <= addr_ff;
               csum_wd_ff <= csum_sat;
               if (last_ff && ccnt_rd != CNT_MAX) begin
                  ccnt_we_ff <= 1'b1;
                  cwa_ff     <= caddr_ff;
                  ccnt_wd_ff <= ccnt_rd + 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_FA: begin
               if (cnt_rd != '0) begin
                  div_start_ff <= 1'b1;
                  div_dvd_ff   <= mean_dvd;
                  div_dvs_ff   <= cnt_rd;
                  neg_ff       <= sum_rd[SUM_W-1];
                  state_ff     <= S_FA_MDIV;
               end else if (ccnt_rd != '0) begin
                  div_start_ff <= 1'b1;
                  div_dvd_ff   <= csum_rd;
                  div_dvs_ff   <= ccnt_rd;
                  state_ff     <= S_FA_VDIV;
               end else begin
                  state_ff <= S_FA_NEXT;
               end
            end
            S_FA_MDIV: begin
               if (div_done) begin
                  msum_ff <= msum_ff + {{CL_W{mean_q[MEAN_W-1]}}, mean_q};
                  n_ff    <= n_ff + 1'b1;
                  if (ccnt_rd != '0) begin
                     div_start_ff <= 1'b1;
                     div_dvd_ff   <= csum_rd;
                     div_dvs_ff   <= ccnt_rd;
                     state_ff     <= S_FA_VDIV;
                  end else begin
                     state_ff <= S_FA_NEXT;
                  end
               end
            end
            S_FA_VDIV: begin
               if (div_done) begin
                  vsum_ff  <= vsum_ff + VSUM_W'(v_clamp);
                  nv_ff    <= nv_ff + 1'b1;
                  state_ff <= S_FA_NEXT;
               end
            end
            S_FA_NEXT: begin
               if (k_ff == '1) begin
                  if (n_ff == '0) begin
                     nomem_ff <= 1'b1;
                     mom_ff   <= '0;
                     vom_ff   <= '0;
                     mov_ff   <= '0;
                     state_ff <= S_EMIT;
                  end else begin
                     div_start_ff <= 1'b1;
                     div_dvd_ff   <= DVD_W'(msum_abs);
                     div_dvs_ff   <= DVS_W'(n_ff);
                     neg_ff       <= msum_ff[MSUM_W-1];
                     state_ff     <= S_FB_MOM;
                  end
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  addr_ff  <= {k_ff + 1'b1, pt_ff};
                  caddr_ff <= k_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_FB_MOM: begin
               if (div_done) begin
                  mom_ff   <= neg_ff ? -$signed(div_q[MEAN_W-1:0])
                                     : $signed(div_q[MEAN_W-1:0]);
                  k_ff     <= '0;
                  addr_ff  <= {CL_W'(0), pt_ff};
                  caddr_ff <= '0;
                  pass_ff  <= 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_FB: begin
               if (cnt_rd != '0) begin
                  div_start_ff <= 1'b1;
                  div_dvd_ff   <= mean_dvd;
                  div_dvs_ff   <= cnt_rd;
                  neg_ff       <= sum_rd[SUM_W-1];
                  state_ff     <= S_FB_MDIV;
               end else begin
                  state_ff <= S_FB_NEXT;
               end
            end
            S_FB_MDIV: begin
               if (div_done) begin
                  m_ff     <= mean_q;
                  state_ff <= S_FB_MUL;
               end
            end
            S_FB_MUL: begin
               prod_ff  <= prod;
               state_ff <= S_FB_ACC;
            end
            S_FB_ACC: begin
               sqsum_ff <= sqsum_ff + DVD_W'(prod_ff);
               state_ff <= S_FB_NEXT;
            end
            S_FB_NEXT: begin
               if (k_ff == '1) begin
                  div_start_ff <= 1'b1;
                  div_dvd_ff   <= sqsum_ff;
                  div_dvs_ff   <= DVS_W'(n_ff);
                  state_ff     <= S_F_VOM;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  addr_ff  <= {k_ff + 1'b1, pt_ff};
                  caddr_ff <= k_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_F_VOM: begin
               if (div_done) begin
                  vom_ff <= vom_sat;
                  if (nv_ff != '0) begin
                     div_start_ff <= 1'b1;
                     div_dvd_ff   <= DVD_W'(vsum_ff);
                     div_dvs_ff   <= DVS_W'(nv_ff);
                     state_ff     <= S_F_MOV;
                  end else begin
                     mov_ff   <= '0;
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_F_MOV: begin
               if (div_done) begin
                  mov_ff   <= div_q[V_W-1:0];
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!out_valid_ff || rsp_tready) begin
                  out_valid_ff <= 1'b1;
                  out_pt_ff    <= pt_ff;
                  out_mom_ff   <= mom_ff;
                  out_vom_ff   <= vom_ff;
                  out_mov_ff   <= mov_ff;
                  out_nomem_ff <= nomem_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({out_mov_ff, out_vom_ff, out_mom_ff, out_pt_ff});
   assign rsp_tuser  = out_nomem_ff;

endmodule

// ===== sv/class_trace_snr_statistics.sv =====
// Per-class trace statistics for signal-to-noise estimation.
// Request channel req_*: opcode in tuser (0 add sample, 1 add centred square,
// 2 finalize a point, 3 dropped); class, point and sample in tdata; tlast
// marks the final point of a trace and bumps the class trace count.
// Response channel rsp_*: one response per finalize request carrying the
// point, mean of class means, variance of means and mean of class variances
// (8 fraction bits); tuser flags that no class holds any trace.
// Add-sample requests are a read-modify-write of the class stores, and
// centred-square requests also run the one-bit-per-cycle divider for the
// class mean unless the class holds no trace. A finalize walks all 256
// classes through that same divider, and walks them a second time when
// any class holds a trace.
// A four-entry command queue in front lets requests be taken while the
// execution side is busy or a response waits.
// After reset the class stores are zeroed one entry a cycle, with
// req_tready low. A response held by a low rsp_tready stays in the
// output register; execution carries on until the next response is ready.
module class_trace_snr_statistics
   import ctss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // class_value, point_index, sample
   input  logic [1:0]             req_tuser,   // opcode
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // point_out, mean_of_means, variance_of_means, mean_of_variances
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser    // no_members
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    init_done;

   ctss_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .init_done(init_done), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
   );

   ctss_back u_back (
      .clock(clock), .reset(reset),
      .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .init_done(init_done),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

`ifndef NO_ASSERTIONS
   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !req_tready)
      else $error("request accepted during store clearing");

   a_ready_low_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request ready straight after reset");

   a_empty_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[RSP_TDATA_W-1:PT_W] == '0)
      else $error("empty result carries non-zero statistics");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from empty queue");
`endif

endmodule

// ===== tb/tb_top.sv =====
// testbench for the per-class trace statistics block: table, random traces, predictor
module tb_top
   import ctss_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SUM_HI  = 64'sd549755813887;
   localparam longint SUM_LO  = -64'sd549755813888;
   localparam longint unsigned CSUM_HI = 64'd72057594037927935;
   localparam longint unsigned V40_HI  = 64'd1099511627775;

   typedef struct {
      logic [PT_W-1:0]          point;
      logic signed [MEAN_W-1:0] mom;
      logic [V_W-1:0]           vom;
      logic [V_W-1:0]           mov;
      logic                     empty;
   } stats_type;

   typedef struct {
      logic [1:0]              op;
      logic [CL_W-1:0]         cls;
      logic [PT_W-1:0]         pt;
      logic signed [SMP_W-1:0] smp;
      logic                    last;
      bit                      typed;
      stats_type               want;
   } row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // class_value, point_index, sample
   logic [1:0]             req_tuser = '0;   // opcode
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // point_out, mean_of_means, variance_of_means, mean_of_variances
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;        // no_members

   class_trace_snr_statistics u_top (.*);

   // predictor state, sparse over class * POINTS + point
   longint          sum_store[int];
   longint unsigned csum_store[int];
   int unsigned     trace_cnt[CLASSES];
   int unsigned     ctrace_cnt[CLASSES];

   stats_type stats_q[$];
   row_type   dir_q[$];
   int        errors = 0;
   int        stats_seen = 0;
   bit        quiet = 0;
   bit        hold_long = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic longint class_mean(int c, int p);
      longint s, m;
      int     idx;
      if (trace_cnt[c] == 0) return 0;
      idx = c * POINTS + p;
      s = sum_store.exists(idx) ? sum_store[idx] : 0;
      m = (s * 256) / longint'(trace_cnt[c]);
      if (m > 64'sd8388607) m = 64'sd8388607;
      if (m < -64'sd8388608) m = -64'sd8388608;
      return m;
   endfunction

   // applies one accepted request; returns 1 when it produces a statistics response
   function automatic bit apply_request(row_type r, output stats_type st);
      int c, p, idx, n, nv;
      longint s, v, d, msum, mom;
      longint unsigned sq, cur, sqsum, vsum, vv;
      c = int'(r.cls);
      p = int'(r.pt);
      idx = c * POINTS + p;
      s = longint'(r.smp);
      st = '{default: '0};
      case (r.op)
         OP_ADD: begin
            v = (sum_store.exists(idx) ? sum_store[idx] : 0) + s;
            if (v > SUM_HI) v = SUM_HI;
            if (v < SUM_LO) v = SUM_LO;
            sum_store[idx] = v;
            if (r.last && trace_cnt[c] < CNT_MAX) trace_cnt[c]++;
            return 0;
         end
         OP_CENTER: begin
            d = s * 256 - class_mean(c, p);
            sq = longint'(d * d) >> 8;
            cur = csum_store.exists(idx) ? csum_store[idx] : 0;
            csum_store[idx] = (sq > CSUM_HI - cur) ? CSUM_HI : cur + sq;
            if (r.last && ctrace_cnt[c] < CNT_MAX) ctrace_cnt[c]++;
            return 0;
         end
         OP_FINAL: begin
            n = 0; nv = 0; msum = 0; sqsum = 0; vsum = 0;
            for (int k = 0; k < CLASSES; k++) begin
               if (trace_cnt[k] != 0) begin
                  msum += class_mean(k, p);
                  n++;
               end
               if (ctrace_cnt[k] != 0) begin
                  cur = csum_store.exists(k * POINTS + p) ? csum_store[k * POINTS + p] : 0;
                  vv = cur / longint'(ctrace_cnt[k]);
                  if (vv > V40_HI) vv = V40_HI;
                  vsum += vv;
                  nv++;
               end
            end
            st.point = r.pt;
            if (n == 0) begin
               st.empty = 1'b1;
               return 1;
            end
            mom = msum / n;
            for (int k = 0; k < CLASSES; k++)
               if (trace_cnt[k] != 0) begin
                  d = class_mean(k, p) - mom;
                  sqsum += longint'(d * d);
               end
            vv = (sqsum / n) >> 8;
            st.mom = mom[MEAN_W-1:0];
            st.vom = (vv > V40_HI) ? V40_HI[V_W-1:0] : vv[V_W-1:0];
            st.mov = (nv != 0) ? V_W'(vsum / nv) : '0;
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   function automatic int draw_gap();
      if (quiet || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 8);
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0h want %0h (point %0d)", what, got, want,
               rsp_tdata[PT_W-1:0]);
   endtask

   task automatic send(row_type r);
      int        g;
      stats_type st;
      g = draw_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tlast  <= r.last;
      req_tdata  <= {6'd0, r.smp, r.pt, r.cls};
      do @(posedge clock); while (!req_tready);
      if (apply_request(r, st))
         stats_q.push_back(r.typed ? r.want : st);
   endtask

   function automatic row_type mk(logic [1:0] op, int cls, int pt, int smp, bit last);
      row_type r;
      r = '{op: op, cls: CL_W'(cls), pt: PT_W'(pt), smp: SMP_W'(smp), last: last,
            typed: 0, want: '{default: '0}};
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      stats_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         stats_seen++;
         if (stats_q.size() == 0) begin
            report("unexpected response", 1, 0);
         end else begin
            w = stats_q.pop_front();
            if (rsp_tdata[9:0] !== w.point) report("point_out", rsp_tdata[9:0], w.point);
            if (rsp_tdata[33:10] !== w.mom) report("mean_of_means", rsp_tdata[33:10], w.mom);
            if (rsp_tdata[73:34] !== w.vom)
               report("variance_of_means", rsp_tdata[73:34], w.vom);
            if (rsp_tdata[113:74] !== w.mov)
               report("mean_of_variances", rsp_tdata[113:74], w.mov);
            if (rsp_tuser !== w.empty) report("no_members", rsp_tuser, w.empty);
         end
      end
   end

   // response side
   initial begin
      int g;
      @(negedge reset);
      forever begin
         g = draw_gap();
         if (hold_long) begin
            // long enough for a second finalize to back up behind the held response
            g = 60000;
            hold_long = 0;
         end
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // request side
   initial begin
      row_type r;
      int      sent, since_final, cls, kind;
      bit      did_hold, did_drain;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // right after reset no class is populated
      r = mk(OP_FINAL, 0, 5, 0, 0);
      r.typed = 1;
      r.want = '{point: 10'd5, mom: '0, vom: '0, mov: '0, empty: 1'b1};
      dir_q.push_back(r);
      dir_q.push_back(mk(OP_UNUSED_CODE, 255, 1023, -1, 1));
      dir_q.push_back(mk(OP_ADD, 0, 0, 32767, 0));
      dir_q.push_back(mk(OP_ADD, 0, 1, -32768, 1));
      dir_q.push_back(mk(OP_ADD, 255, 1023, -1, 1));
      dir_q.push_back(mk(OP_ADD, 255, 0, 0, 1));
      // populated classes but none centred yet
      dir_q.push_back(mk(OP_FINAL, 0, 1, 0, 0));
      dir_q.push_back(mk(OP_FINAL, 0, 1023, 0, 0));
      // centring on a class with no traces uses a zero mean
      dir_q.push_back(mk(OP_CENTER, 3, 0, 100, 1));
      dir_q.push_back(mk(OP_CENTER, 0, 0, 32767, 1));
      dir_q.push_back(mk(OP_CENTER, 255, 1023, -32768, 1));
      dir_q.push_back(mk(OP_CENTER, 170, 682, 21845, 0));
      dir_q.push_back(mk(OP_FINAL, 85, 0, 0, 0));
      dir_q.push_back(mk(OP_FINAL, 0, 1023, 0, 0));
      dir_q.push_back(mk(OP_ADD, 128, 512, -21846, 1));
      dir_q.push_back(mk(OP_FINAL, 0, 512, 0, 0));
      foreach (dir_q[i]) send(dir_q[i]);

      sent = 0;
      since_final = 0;
      did_hold = 0;
      did_drain = 0;
      while (sent < 1000) begin
         quiet = ((sent / 64) % 4) == 3;
         if (sent >= 300 && !did_hold) begin
            hold_long = 1;
            did_hold = 1;
         end
         if (sent >= 600 && !did_drain) begin
            wait (stats_q.size() == 0);
            did_drain = 1;
         end
         kind = $urandom_range(0, 99);
         cls = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
         if (since_final >= 35) begin
            // finalize mostly on the busy points
            send(mk(OP_FINAL, $urandom_range(0, 255),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 3), 0, 0));
            sent++;
            since_final = 0;
         end else if (kind < 85) begin
            // a whole trace of four points, summed or centred
            for (int p = 0; p < 4; p++)
               send(mk((kind < 55) ? OP_ADD : OP_CENTER, cls, p,
                       $signed(16'($urandom_range(0, 65535))), p == 3));
            sent += 4;
            since_final += 4;
         end else begin
            send(mk(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                    $urandom_range(0, 1023), $signed(16'($urandom_range(0, 65535))),
                    $urandom_range(0, 1)));
            sent++;
            since_final++;
         end
      end
      req_tvalid <= 1'b0;

      wait (stats_q.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
